@@ rtl/sdfcb_pkg.sv @@
package sdfcb_pkg;

   // Configuration port geometry and register indexes.
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 24;
   localparam logic [CsrIndexW-1:0] CSR_FG_COLOR     = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_EDGE_VALUE   = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_SMOOTH_WIDTH = 2'd2;

   // Register values after reset.
   localparam logic [23:0] FgColorReset     = 24'hffffff;
   localparam logic [7:0]  EdgeValueReset   = 8'd180;
   localparam logic [7:0]  SmoothWidthReset = 8'd40;

   // Ramp division: a 24-bit numerator over the 8-bit width gives a 0.16 ramp position.
   localparam int NumW      = 24;
   localparam int QuoW      = 16;
   localparam int DivSteps  = 4;
   localparam int DivStages = QuoW / DivSteps;

   // Smoothstep and blend constants.
   localparam logic [17:0] SmoothThree = 18'd196608;
   localparam logic [7:0]  AlphaMax    = 8'd255;
   localparam logic [15:0] BlendRound  = 16'd128;
   localparam logic [15:0] Recip255    = 16'h8081;
   localparam logic [31:0] AlphaOpaque = 32'hff000000;

   // Input word as it enters the pipeline.
   typedef struct packed {
      logic [7:0]  tl;
      logic [7:0]  tr;
      logic [7:0]  bl;
      logic [7:0]  br;
      logic [7:0]  fx;
      logic [7:0]  fy;
      logic [23:0] dest;
   } sdfcb_texel_type;

   // Word inside the divider: partial remainder, dividend bits and quotient bits.
   typedef struct packed {
      logic        covered;
      logic        full;
      logic [7:0]  rem;
      logic [15:0] quo;
      logic [23:0] dest;
   } sdfcb_div_type;

   // Word after the coverage alpha is known.
   typedef struct packed {
      logic        covered;
      logic [7:0]  alpha;
      logic [23:0] dest;
   } sdfcb_alpha_type;

endpackage

@@ rtl/sdfcb_req_if.sv @@
interface sdfcb_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  texel_top_left;
   logic [7:0]  texel_top_right;
   logic [7:0]  texel_bottom_left;
   logic [7:0]  texel_bottom_right;
   logic [7:0]  frac_x;
   logic [7:0]  frac_y;
   logic [23:0] dest_color;

   modport source (
      output valid, texel_top_left, texel_top_right, texel_bottom_left,
             texel_bottom_right, frac_x, frac_y, dest_color,
      input  ready
   );
   modport sink (
      input  valid, texel_top_left, texel_top_right, texel_bottom_left,
             texel_bottom_right, frac_x, frac_y, dest_color,
      output ready
   );
endinterface

@@ rtl/sdfcb_rsp_if.sv @@
interface sdfcb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel;
   logic        pixel_written;

   modport source (
      output valid, out_pixel, pixel_written,
      input  ready
   );
   modport sink (
      input  valid, out_pixel, pixel_written,
      output ready
   );
endinterface

@@ rtl/sdfcb_front.sv @@
module sdfcb_front
   import sdfcb_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      edge_value,
   input  logic [7:0]      smooth_width,
   input  logic            in_valid,
   output logic            in_ready,
   input  sdfcb_texel_type in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output sdfcb_div_type   out_word
);

   localparam int OneW  = FRACTION_BITS + 1;
   localparam int TopW  = FRACTION_BITS + 8;
   localparam int ValW  = 2 * FRACTION_BITS + 8;
   localparam int DistW = ValW + 2;
   localparam int WideW = DistW + 16;
   localparam int ShL   = (15 > 2 * FRACTION_BITS) ? 15 - 2 * FRACTION_BITS : 0;
   localparam int ShR   = (2 * FRACTION_BITS > 15) ? 2 * FRACTION_BITS - 15 : 0;
   localparam logic [7:0] FracMask =
      (FRACTION_BITS >= 8) ? 8'hff : 8'((1 << FRACTION_BITS) - 1);
   localparam logic [OneW-1:0] One = {1'b1, {FRACTION_BITS{1'b0}}};

   logic              valid1_ff, valid2_ff, valid3_ff;
   logic              en1, en2, en3;
   logic [OneW-1:0]   fx, fy;
   logic [TopW-1:0]   top1_in, top1_ff, bot1_in, bot1_ff;
   logic [OneW-1:0]   fy1_ff;
   logic [23:0]       dest1_ff, dest2_ff;
   logic [ValW-1:0]   val2_in, val2_ff;
   logic signed [9:0] edge_low;
   logic signed [DistW-1:0] low_end, ramp_pos, span;
   logic [WideW-1:0]  wide;
   sdfcb_div_type     word3_in, word3_ff;

   // A stage takes a new word when it is empty or its word moves on.
   assign en3      = !valid3_ff || out_ready;
   assign en2      = !valid2_ff || en3;
   assign en1      = !valid1_ff || en2;
   assign in_ready = en1;

   // Stage 1: interpolate along x for the top and bottom rows.
   always_comb begin
      fx      = OneW'(in_word.fx & FracMask);
      fy      = OneW'(in_word.fy & FracMask);
      top1_in = TopW'(in_word.tl) * TopW'(One - fx) + TopW'(in_word.tr) * TopW'(fx);
      bot1_in = TopW'(in_word.bl) * TopW'(One - fx) + TopW'(in_word.br) * TopW'(fx);
   end

   // Stage 2: interpolate along y; the distance stays exact.
   assign val2_in = ValW'(top1_ff) * ValW'(One - fy1_ff) + ValW'(bot1_ff) * ValW'(fy1_ff);

   // Stage 3: place the distance on the ramp and form the divider numerator.
   always_comb begin
      edge_low = $signed({2'b00, edge_value}) - $signed({2'b00, smooth_width});
      low_end  = DistW'(edge_low) <<< (2 * FRACTION_BITS);
      ramp_pos = $signed(DistW'(val2_ff)) - low_end;
      span     = $signed(DistW'(smooth_width) << (2 * FRACTION_BITS + 1));
      wide     = (WideW'(ramp_pos[DistW-1:0]) << ShL) >> ShR;
      word3_in.dest = dest2_ff;
      word3_in.rem  = wide[NumW-1:QuoW];
      word3_in.quo  = wide[QuoW-1:0];
      if (smooth_width == 8'd0) begin
         // Hard step at the outline.
         word3_in.covered = val2_ff >= (ValW'(edge_value) << (2 * FRACTION_BITS));
         word3_in.full    = 1'b1;
      end else begin
         word3_in.covered = !ramp_pos[DistW-1] && (ramp_pos != '0);
         word3_in.full    = ramp_pos >= span;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (en1) valid1_ff <= in_valid;
         if (en2) valid2_ff <= valid1_ff;
         if (en3) valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         top1_ff  <= top1_in;
         bot1_ff  <= bot1_in;
         fy1_ff   <= fy;
         dest1_ff <= in_word.dest;
      end
      if (en2) begin
         val2_ff  <= val2_in;
         dest2_ff <= dest1_ff;
      end
      if (en3) begin
         word3_ff <= word3_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_word  = word3_ff;

endmodule

@@ rtl/sdfcb_div_stage.sv @@
module sdfcb_div_stage
   import sdfcb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    smooth_width,
   input  logic          in_valid,
   output logic          in_ready,
   input  sdfcb_div_type in_word,
   output logic          out_valid,
   input  logic          out_ready,
   output sdfcb_div_type out_word
);

   logic          valid_ff;
   logic          en;
   logic [8:0]    rem9;
   sdfcb_div_type word_in, word_ff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   // Restoring division, a few quotient bits per stage. Dividend bits leave the
   // top of quo while quotient bits enter at the bottom.
   always_comb begin
      word_in = in_word;
      rem9    = '0;
      for (int k = 0; k < DivSteps; k++) begin
         rem9        = {word_in.rem, word_in.quo[QuoW-1]};
         word_in.quo = {word_in.quo[QuoW-2:0], 1'b0};
         if (rem9 >= {1'b0, smooth_width}) begin
            rem9           = rem9 - {1'b0, smooth_width};
            word_in.quo[0] = 1'b1;
         end
         word_in.rem = rem9[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ rtl/sdfcb_smooth.sv @@
module sdfcb_smooth
   import sdfcb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  sdfcb_div_type   in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output sdfcb_alpha_type out_word
);

   logic            valid1_ff, valid2_ff, valid3_ff;
   logic            en1, en2, en3;
   logic [15:0]     t1_ff;
   logic [31:0]     sq1_in, sq1_ff;
   logic [49:0]     prod2_in, prod2_ff;
   logic [57:0]     scaled;
   logic [9:0]      raw_alpha;
   logic [7:0]      ramp_alpha;
   logic [1:0]      flags1_ff, flags2_ff;
   logic [23:0]     dest1_ff, dest2_ff;
   sdfcb_alpha_type word3_in, word3_ff;

   assign en3      = !valid3_ff || out_ready;
   assign en2      = !valid2_ff || en3;
   assign en1      = !valid1_ff || en2;
   assign in_ready = en1;

   // Stage 1: square of the ramp position.
   assign sq1_in = 32'(in_word.quo) * 32'(in_word.quo);

   // Stage 2: t^2 * (3 - 2t) in 0.16 terms.
   assign prod2_in = 50'(sq1_ff) * 50'(SmoothThree - 18'({t1_ff, 1'b0}));

   // Stage 3: scale by 255, round half up and saturate.
   always_comb begin
      scaled     = (58'(prod2_ff) << 8) - 58'(prod2_ff) + (58'(1) << 47);
      raw_alpha  = scaled[57:48];
      ramp_alpha = (raw_alpha > 10'(AlphaMax)) ? AlphaMax : raw_alpha[7:0];
      word3_in.covered = flags2_ff[1];
      word3_in.dest    = dest2_ff;
      if (!flags2_ff[1]) begin
         word3_in.alpha = '0;
      end else if (flags2_ff[0]) begin
         word3_in.alpha = AlphaMax;
      end else begin
         word3_in.alpha = ramp_alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (en1) valid1_ff <= in_valid;
         if (en2) valid2_ff <= valid1_ff;
         if (en3) valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         t1_ff     <= in_word.quo;
         sq1_ff    <= sq1_in;
         flags1_ff <= {in_word.covered, in_word.full};
         dest1_ff  <= in_word.dest;
      end
      if (en2) begin
         prod2_ff  <= prod2_in;
         flags2_ff <= flags1_ff;
         dest2_ff  <= dest1_ff;
      end
      if (en3) begin
         word3_ff  <= word3_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_word  = word3_ff;

endmodule

@@ rtl/sdfcb_blend.sv @@
module sdfcb_blend
   import sdfcb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [23:0]     fg_color,
   input  logic            in_valid,
   output logic            in_ready,
   input  sdfcb_alpha_type in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [31:0]     out_pixel,
   output logic            pixel_written
);

   logic        valid1_ff, valid2_ff, valid3_ff;
   logic        en1, en2, en3;
   logic        cov1_ff, cov2_ff;
   logic [15:0] yf1_in [3];
   logic [15:0] yd1_in [3];
   logic [15:0] yf1_ff [3];
   logic [15:0] yd1_ff [3];
   logic [31:0] pf, pd;
   logic [7:0]  qf2_in [3];
   logic [7:0]  qd2_in [3];
   logic [7:0]  qf2_ff [3];
   logic [7:0]  qd2_ff [3];
   logic [8:0]  sum;
   logic [7:0]  chan [3];
   logic [31:0] pixel3_in, pixel3_ff;
   logic        written3_ff;

   assign en3      = !valid3_ff || out_ready;
   assign en2      = !valid2_ff || en3;
   assign en1      = !valid1_ff || en2;
   assign in_ready = en1;

   // Stage 1: weighted channel terms with the rounding offset; lane 0 is blue.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         yf1_in[c] = 16'(fg_color[8*c +: 8]) * 16'(in_word.alpha) + BlendRound;
         yd1_in[c] = 16'(in_word.dest[8*c +: 8]) * 16'(AlphaMax - in_word.alpha)
                     + BlendRound;
      end
   end

   // Stage 2: divide each term by 255 through a reciprocal multiply.
   always_comb begin
      pf = '0;
      pd = '0;
      for (int c = 0; c < 3; c++) begin
         pf        = 32'(yf1_ff[c]) * 32'(Recip255);
         pd        = 32'(yd1_ff[c]) * 32'(Recip255);
         qf2_in[c] = pf[30:23];
         qd2_in[c] = pd[30:23];
      end
   end

   // Stage 3: add, saturate and pack; an uncovered pixel reads as zero.
   always_comb begin
      sum = '0;
      for (int c = 0; c < 3; c++) begin
         sum     = 9'(qf2_ff[c]) + 9'(qd2_ff[c]);
         chan[c] = sum[8] ? AlphaMax : sum[7:0];
      end
      pixel3_in = cov2_ff ? (AlphaOpaque | {8'h00, chan[2], chan[1], chan[0]}) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (en1) valid1_ff <= in_valid;
         if (en2) valid2_ff <= valid1_ff;
         if (en3) valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         yf1_ff  <= yf1_in;
         yd1_ff  <= yd1_in;
         cov1_ff <= in_word.covered;
      end
      if (en2) begin
         qf2_ff  <= qf2_in;
         qd2_ff  <= qd2_in;
         cov2_ff <= cov1_ff;
      end
      if (en3) begin
         pixel3_ff   <= pixel3_in;
         written3_ff <= cov2_ff;
      end
   end

   assign out_valid     = valid3_ff;
   assign out_pixel     = pixel3_ff;
   assign pixel_written = written3_ff;

endmodule

@@ rtl/sdf_glyph_coverage_blend_core.sv @@
// Distance-field text coverage and blend, one pixel per word.
// The request channel carries four neighboring distance texels, the x and y
// sample fractions and the destination RGB color. The response channel returns
// the blended pixel with its alpha byte forced to 0xff, and a flag that tells
// whether the pixel is covered and should be written; an uncovered pixel
// returns zero with the flag low.
// The csr port writes the foreground color, the outline value and the ramp
// half width. Write them only while no word is in flight.
// The pipeline has 13 register stages: three of interpolation and ramp placement,
// four of the ramp divider (four quotient bits each), three of smoothstep and
// three of blending. Throughput is one word per cycle; while the receiver keeps
// ready high, a new request is accepted every cycle.
// Every stage holds its own valid bit, so when the receiver stalls the pipeline
// keeps accepting words until each stage is full, and then holds without losing
// or repeating any word.
// A synchronous reset empties the pipeline and restores the csr registers to
// white, 180 and 40.
module sdf_glyph_coverage_blend_core
   import sdfcb_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   sdfcb_req_if.sink            req_port,
   sdfcb_rsp_if.source          rsp_port,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   logic [23:0]     fg_color_in, fg_color_ff;
   logic [7:0]      edge_value_in, edge_value_ff;
   logic [7:0]      smooth_width_in, smooth_width_ff;
   sdfcb_texel_type req_word;
   logic            div_valid [DivStages+1];
   logic            div_ready [DivStages+1];
   sdfcb_div_type   div_word  [DivStages+1];
   logic            alpha_valid, alpha_ready;
   sdfcb_alpha_type alpha_word;

   // Configuration register writes.
   always_comb begin
      fg_color_in     = fg_color_ff;
      edge_value_in   = edge_value_ff;
      smooth_width_in = smooth_width_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FG_COLOR:     fg_color_in     = csr_data;
            CSR_EDGE_VALUE:   edge_value_in   = csr_data[7:0];
            CSR_SMOOTH_WIDTH: smooth_width_in = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff     <= FgColorReset;
         edge_value_ff   <= EdgeValueReset;
         smooth_width_ff <= SmoothWidthReset;
      end else begin
         fg_color_ff     <= fg_color_in;
         edge_value_ff   <= edge_value_in;
         smooth_width_ff <= smooth_width_in;
      end
   end

   // Gather the request payload into one word.
   always_comb begin
      req_word.tl   = req_port.texel_top_left;
      req_word.tr   = req_port.texel_top_right;
      req_word.bl   = req_port.texel_bottom_left;
      req_word.br   = req_port.texel_bottom_right;
      req_word.fx   = req_port.frac_x;
      req_word.fy   = req_port.frac_y;
      req_word.dest = req_port.dest_color;
   end

   // Interpolation and ramp placement.
   sdfcb_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .edge_value   (edge_value_ff),
      .smooth_width (smooth_width_ff),
      .in_valid     (req_port.valid),
      .in_ready     (req_port.ready),
      .in_word      (req_word),
      .out_valid    (div_valid[0]),
      .out_ready    (div_ready[0]),
      .out_word     (div_word[0])
   );

   // Ramp position divider, one stage per group of quotient bits.
   for (genvar g = 0; g < DivStages; g++) begin : g_div
      sdfcb_div_stage u_div (
         .clock        (clock),
         .reset        (reset),
         .smooth_width (smooth_width_ff),
         .in_valid     (div_valid[g]),
         .in_ready     (div_ready[g]),
         .in_word      (div_word[g]),
         .out_valid    (div_valid[g+1]),
         .out_ready    (div_ready[g+1]),
         .out_word     (div_word[g+1])
      );
   end

   // Smoothstep to an 8-bit coverage alpha.
   sdfcb_smooth u_smooth (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[DivStages]),
      .in_ready  (div_ready[DivStages]),
      .in_word   (div_word[DivStages]),
      .out_valid (alpha_valid),
      .out_ready (alpha_ready),
      .out_word  (alpha_word)
   );

   // Color blend and response register.
   sdfcb_blend u_blend (
      .clock         (clock),
      .reset         (reset),
      .fg_color      (fg_color_ff),
      .in_valid      (alpha_valid),
      .in_ready      (alpha_ready),
      .in_word       (alpha_word),
      .out_valid     (rsp_port.valid),
      .out_ready     (rsp_port.ready),
      .out_pixel     (rsp_port.out_pixel),
      .pixel_written (rsp_port.pixel_written)
   );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import sdfcb_pkg::*;

   localparam int FracBits = 8;

   // Expected response word: blended pixel and write flag.
   typedef struct packed {
      logic [31:0] pixel;
      logic        written;
   } blend_result_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_data;

   sdfcb_req_if req_bus ();
   sdfcb_rsp_if rsp_bus ();

   sdf_glyph_coverage_blend_core #(
      .FRACTION_BITS(FracBits)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus.sink),
      .rsp_port  (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Words waiting to be sent and blended pixels waiting to come back.
   sdfcb_texel_type  texel_words[$];
   blend_result_type expected_pixels[$];
   blend_result_type want;
   int errors = 0;
   int send_gap;
   int stall_left;
   bit idle_on;

   // Shadow copy of the csr registers, tracked from the write port.
   logic [23:0] fg_shadow;
   logic [7:0]  outline_shadow;
   logic [7:0]  ramp_shadow;

   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long.
   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One color channel: both terms rounded, the sum saturated.
   function automatic logic [7:0] blend_channel(int unsigned fg, int unsigned dst,
                                                int unsigned alpha);
      int unsigned sum;
      sum = (fg * alpha + 128) / 255 + (dst * (255 - alpha) + 128) / 255;
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   // Coverage from the bilinear distance and smoothstep ramp, then the blend.
   function automatic blend_result_type blend_pixel(sdfcb_texel_type w);
      longint unsigned one, fx, fy, top, bot, tq, poly;
      longint          val, d, r, s2;
      int unsigned     alpha;
      bit              covered;
      blend_result_type res;
      one  = 64'd1 << FracBits;
      fx   = longint'(w.fx) & (one - 1);
      fy   = longint'(w.fy) & (one - 1);
      top  = longint'(w.tl) * (one - fx) + longint'(w.tr) * fx;
      bot  = longint'(w.bl) * (one - fx) + longint'(w.br) * fx;
      val  = top * (one - fy) + bot * fy;
      s2   = one * one;
      alpha = 255;
      if (ramp_shadow == 0) begin
         covered = val >= longint'(outline_shadow) * s2;
      end else begin
         d = val - (longint'(outline_shadow) - longint'(ramp_shadow)) * s2;
         r = 2 * longint'(ramp_shadow) * s2;
         covered = d > 0;
         if (d <= 0) begin
            alpha = 0;
         end else if (d < r) begin
            tq    = (d * 65536) / r;
            poly  = 255 * tq * tq * (3 * 65536 - 2 * tq);
            alpha = 32'((poly + (64'd1 << 47)) >> 48);
            if (alpha > 255) alpha = 255;
         end
      end
      res.written = covered;
      res.pixel   = '0;
      if (covered) begin
         res.pixel = AlphaOpaque
                   | {8'd0, blend_channel(fg_shadow[23:16], w.dest[23:16], alpha), 16'd0}
                   | {16'd0, blend_channel(fg_shadow[15:8], w.dest[15:8], alpha), 8'd0}
                   | {24'd0, blend_channel(fg_shadow[7:0], w.dest[7:0], alpha)};
      end
      return res;
   endfunction

   // Random word; most texels are drawn near the ramp so that all of it is hit.
   function automatic sdfcb_texel_type random_word();
      sdfcb_texel_type w;
      int lo, hi;
      lo = int'(outline_shadow) - int'(ramp_shadow) - 4;
      hi = int'(outline_shadow) + int'(ramp_shadow) + 4;
      if (lo < 0) lo = 0;
      if (hi > 255) hi = 255;
      if ($urandom_range(0, 9) < 6) begin
         w.tl = 8'($urandom_range(hi, lo));
         w.tr = 8'($urandom_range(hi, lo));
         w.bl = 8'($urandom_range(hi, lo));
         w.br = 8'($urandom_range(hi, lo));
      end else begin
         w.tl = 8'($urandom);
         w.tr = 8'($urandom);
         w.bl = 8'($urandom);
         w.br = 8'($urandom);
      end
      case ($urandom_range(0, 7))
         0: begin
            w.fx = 8'd0;
            w.fy = 8'd255;
         end
         1: begin
            w.fx = 8'd255;
            w.fy = 8'd0;
         end
         default: begin
            w.fx = 8'($urandom);
            w.fy = 8'($urandom);
         end
      endcase
      w.dest = 24'($urandom);
      return w;
   endfunction

   // Request driver: presents queued words with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= send_gap - 1;
         end else if (texel_words.size() != 0) begin
            req_bus.texel_top_left     <= texel_words[0].tl;
            req_bus.texel_top_right    <= texel_words[0].tr;
            req_bus.texel_bottom_left  <= texel_words[0].bl;
            req_bus.texel_bottom_right <= texel_words[0].br;
            req_bus.frac_x             <= texel_words[0].fx;
            req_bus.frac_y             <= texel_words[0].fy;
            req_bus.dest_color         <= texel_words[0].dest;
            req_bus.valid              <= 1'b1;
            texel_words.delete(0);
            send_gap <= next_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response receiver: ready drops for random stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 7) == 0) stall_left <= next_gap();
      end
   end

   // Register shadow follows every csr write.
   always @(posedge clock) begin
      if (reset) begin
         fg_shadow      <= FgColorReset;
         outline_shadow <= EdgeValueReset;
         ramp_shadow    <= SmoothWidthReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FG_COLOR:     fg_shadow      <= csr_data[23:0];
            CSR_EDGE_VALUE:   outline_shadow <= csr_data[7:0];
            CSR_SMOOTH_WIDTH: ramp_shadow    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Monitor: predict on each accepted request, compare each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_pixels.push_back(blend_pixel('{
               tl: req_bus.texel_top_left, tr: req_bus.texel_top_right,
               bl: req_bus.texel_bottom_left, br: req_bus.texel_bottom_right,
               fx: req_bus.frac_x, fy: req_bus.frac_y, dest: req_bus.dest_color}));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: response with none expected: pixel %h written %b",
                        $time, rsp_bus.out_pixel, rsp_bus.pixel_written);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.out_pixel !== want.pixel) begin
                  $display("%0t: out_pixel expected %h actual %h",
                           $time, want.pixel, rsp_bus.out_pixel);
                  errors++;
               end
               if (rsp_bus.pixel_written !== want.written) begin
                  $display("%0t: pixel_written expected %b actual %b",
                           $time, want.written, rsp_bus.pixel_written);
                  errors++;
               end
            end
         end
      end
   end

   // Sender holds off until every expected pixel is back and the pipeline is empty.
   task automatic settle();
      while (texel_words.size() != 0 || req_bus.valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIndexW-1:0] index, logic [CsrDataW-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // New register setting, written only once the block is idle.
   task automatic set_regs(logic [23:0] fg, logic [7:0] outline, logic [7:0] ramp);
      settle();
      csr_write(CSR_FG_COLOR, fg);
      csr_write(CSR_EDGE_VALUE, {16'd0, outline});
      csr_write(CSR_SMOOTH_WIDTH, {16'd0, ramp});
      @(posedge clock);
   endtask

   task automatic send(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl, logic [7:0] br,
                       logic [7:0] fx, logic [7:0] fy, logic [23:0] dest);
      texel_words.push_back('{tl: tl, tr: tr, bl: bl, br: br, fx: fx, fy: fy, dest: dest});
   endtask

   // Run limit, far above the slowest correct run.
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // Stimulus: directed corners first, then random phases with new settings.
   initial begin
      logic [7:0] outline;
      logic [7:0] ramp;
      clock     = 1'b0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      idle_on   = 1'b0;
      req_bus.valid              = 1'b0;
      req_bus.texel_top_left     = '0;
      req_bus.texel_top_right    = '0;
      req_bus.texel_bottom_left  = '0;
      req_bus.texel_bottom_right = '0;
      req_bus.frac_x             = '0;
      req_bus.frac_y             = '0;
      req_bus.dest_color         = '0;
      rsp_bus.ready              = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings after reset: below, on and above the ramp, fraction extremes.
      send(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 24'h123456);
      send(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 24'h000000);
      send(8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 24'hffffff);
      send(8'd0, 8'd200, 8'd0, 8'd0, 8'd255, 8'd0, 24'h00ff00);
      send(8'd0, 8'd0, 8'd200, 8'd0, 8'd0, 8'd255, 24'hff0000);
      send(8'd10, 8'd60, 8'd170, 8'd250, 8'd255, 8'd255, 24'h0000ff);
      // Barely inside the ramp start: coverage rounds to zero but is written.
      send(8'd140, 8'd140, 8'd140, 8'd141, 8'd1, 8'd1, 24'h5a5a5a);
      send(8'd140, 8'd140, 8'd140, 8'd140, 8'd77, 8'd99, 24'ha5a5a5);
      send(8'd220, 8'd220, 8'd220, 8'd220, 8'd3, 8'd200, 24'h808080);
      send(8'd180, 8'd180, 8'd180, 8'd180, 8'd128, 8'd128, 24'h000000);

      // Zero width: hard step at the outline.
      set_regs(24'h3c6e9f, 8'd180, 8'd0);
      send(8'd179, 8'd179, 8'd179, 8'd179, 8'd0, 8'd0, 24'hffffff);
      send(8'd180, 8'd180, 8'd180, 8'd180, 8'd0, 8'd0, 24'h000000);
      send(8'd179, 8'd179, 8'd179, 8'd180, 8'd255, 8'd255, 24'h7f7f7f);

      // Ramp that starts below zero.
      set_regs(24'hc39660, 8'd10, 8'd40);
      send(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 24'h102030);
      send(8'd25, 8'd25, 8'd25, 8'd25, 8'd0, 8'd0, 24'hfedcba);

      // Register extremes.
      set_regs(24'h000000, 8'd255, 8'd255);
      send(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 24'hffffff);
      send(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 24'hffffff);
      set_regs(24'hffffff, 8'd0, 8'd255);
      send(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 24'h000000);
      set_regs(24'haaaaaa, 8'd0, 8'd0);
      send(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 24'h555555);
      set_regs(24'h555555, 8'd255, 8'd0);
      send(8'd255, 8'd255, 8'd255, 8'd255, 8'd17, 8'd230, 24'haaaaaa);
      send(8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 24'haaaaaa);

      // Random phases, each under a fresh setting; one phase runs without idling.
      for (int phase = 0; phase < 8; phase++) begin
         outline = 8'($urandom);
         ramp    = 8'($urandom);
         case ($urandom_range(0, 5))
            0: ramp = 8'd0;
            1: ramp = 8'd255;
            2: ramp = 8'($urandom_range(1, 8));
            default: ;
         endcase
         if (phase == 1) outline = 8'd0;
         if (phase == 5) outline = 8'd255;
         set_regs(24'($urandom), outline, ramp);
         idle_on = (phase != 3);
         for (int n = 0; n < 232; n++) texel_words.push_back(random_word());
      end

      settle();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
